// ----- design/hyaw_pkg.sv -----
// Shared types, widths and constants for the heading yaw block.
// No dependencies; every other file of the block imports this package.
package hyaw_pkg;

   localparam int COORD_W        = 30;   // coordinate and register width
   localparam int DELTA_W        = COORD_W + 1;
   localparam int PRESCALE_SHIFT = 24;   // vector is scaled by 2^24
   localparam int XY_W           = 58;   // holds |v| * gain * 2^24 with margin
   localparam int ANG_W          = 34;   // angle in 2^-16 centidegree
   localparam int YAW_W          = 16;
   localparam int TABLE_LEN      = 24;
   localparam int CSR_ADDR_W     = 1;
   localparam int REQ_DATA_W     = 64;   // two coordinates padded to bytes
   localparam int RSP_DATA_W     = 16;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_DEST_X = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_DEST_Z = 1'b1;

   // 180 degrees in 2^-16 centidegree
   localparam logic signed [ANG_W-1:0] HALF_TURN_Q = 34'sd1179648000;

   typedef struct packed {
      logic                    vld;
      logic                    zero;   // start equals destination
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ANG_W-1:0] ang;
   } cordic_stage_type;

   // atan(2^-i) in 2^-16 centidegree, rounded to nearest
   function automatic logic signed [ANG_W-1:0] atan_q(input int idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         0:       v = 34'sd294912000;
         1:       v = 34'sd174096719;
         2:       v = 34'sd91987925;
         3:       v = 34'sd46694507;
         4:       v = 34'sd23437865;
         5:       v = 34'sd11730358;
         6:       v = 34'sd5866610;
         7:       v = 34'sd2933484;
         8:       v = 34'sd1466764;
         9:       v = 34'sd733385;
         10:      v = 34'sd366693;
         11:      v = 34'sd183346;
         12:      v = 34'sd91673;
         13:      v = 34'sd45837;
         14:      v = 34'sd22918;
         15:      v = 34'sd11459;
         16:      v = 34'sd5730;
         17:      v = 34'sd2865;
         18:      v = 34'sd1432;
         19:      v = 34'sd716;
         20:      v = 34'sd358;
         21:      v = 34'sd179;
         22:      v = 34'sd90;
         23:      v = 34'sd45;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/heading_yaw_from_two_points_top.sv -----
// Top level of the heading yaw block: configuration registers, CORDIC chain,
// output register and skid entry. Depends on hyaw_pkg, hyaw_prep, hyaw_cell
// and hyaw_round.
//
// Usage
//   Write the destination point through the csr_ port (index 0 dest_x,
//   index 1 dest_z, 30-bit signed, 1/16 block) while no request is in flight.
//   Each request on req_ carries a start point; one response on rsp_ carries
//   the heading yaw = atan2(-dx, dz) in hundredths of a degree, in
//   (-180, 180], with dx, dz the destination minus the start. Equal points
//   give zero.
// Timing
//   A request passes one entry stage, one cell per CORDIC rotation, one
//   rounding stage and the output register. One request is taken every
//   cycle while req_tready is high; each rotation cell handles a different
//   request, so the cell chain sets the latency and not the rate.
// Reset and stall
//   Reset clears all valid bits and sets the destination to the origin.
//   When rsp_tready is low the response holds in the output register and the
//   chain keeps moving; the next finished result parks in the skid entry,
//   and only then does req_tready drop, so the whole chain holds until the
//   receiver drains the skid entry.
module heading_yaw_from_two_points_top
   import hyaw_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [29:0] start_x, [59:30] start_z, pad
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] yaw_centideg
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [COORD_W-1:0]    csr_wdata
);

   logic signed [COORD_W-1:0] dest_x_ff, dest_z_ff;
   cordic_stage_type          chain [CORDIC_STAGES+1];
   logic                      pipe_en;
   logic                      fin_vld;
   logic signed [YAW_W-1:0]   fin_yaw;
   logic                      out_vld_in, out_vld_ff, skid_vld_in, skid_vld_ff;
   logic signed [YAW_W-1:0]   out_yaw_in, out_yaw_ff, skid_yaw_in, skid_yaw_ff;
   logic                      out_free;

   // Destination registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff <= '0;
         dest_z_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_DEST_X: dest_x_ff <= $signed(csr_wdata);
            REG_DEST_Z: dest_z_ff <= $signed(csr_wdata);
            default:    ;
         endcase
      end
   end

   // The chain advances as long as the skid entry is free
   assign pipe_en    = !skid_vld_ff;
   assign req_tready = pipe_en;

   hyaw_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en_i      (pipe_en),
      .vld_i     (req_tvalid),
      .dest_x_i  (dest_x_ff),
      .dest_z_i  (dest_z_ff),
      .start_x_i ($signed(req_tdata[COORD_W-1:0])),
      .start_z_i ($signed(req_tdata[2*COORD_W-1:COORD_W])),
      .stage_o   (chain[0])
   );

   // One rotation cell per CORDIC iteration
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      hyaw_cell #(
         .SHIFT (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en_i    (pipe_en),
         .stage_i (chain[i]),
         .stage_o (chain[i+1])
      );
   end

   hyaw_round u_round (
      .clock   (clock),
      .reset   (reset),
      .en_i    (pipe_en),
      .stage_i (chain[CORDIC_STAGES]),
      .vld_o   (fin_vld),
      .yaw_o   (fin_yaw)
   );

   // Output register and skid entry
   assign out_free = !out_vld_ff || rsp_tready;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_yaw_in  = out_yaw_ff;
      skid_vld_in = skid_vld_ff;
      skid_yaw_in = skid_yaw_ff;
      if (out_free) begin
         if (skid_vld_ff) begin
            // drain the parked result first; the chain is held this cycle
            out_vld_in  = 1'b1;
            out_yaw_in  = skid_yaw_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in = fin_vld;
            out_yaw_in = fin_yaw;
         end
      end else if (pipe_en && fin_vld) begin
         // park the finished result behind the stalled one
         skid_vld_in = 1'b1;
         skid_yaw_in = fin_yaw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_yaw_ff  <= out_yaw_in;
      skid_yaw_ff <= skid_yaw_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_yaw_ff;

   // A parked result always sits behind a waiting one
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry holds a result while the output register is empty");

   // Taking a response while one is parked refills the output register
   a_skid_refill : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && skid_vld_ff) |=> (rsp_tvalid && !skid_vld_ff))
      else $error("parked result was not moved to the output register");

   // The heading stays in (-180, 180] degrees
   a_yaw_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (($signed(rsp_tdata) >= -16'sd17999)
                      && ($signed(rsp_tdata) <= 16'sd18000)))
      else $error("heading out of range");

endmodule

// ----- design/hyaw_prep.sv -----
// Entry stage: difference vector, half-plane fold and prescale.
// Depends on hyaw_pkg.
module hyaw_prep
   import hyaw_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en_i,
   input  logic                      vld_i,
   input  logic signed [COORD_W-1:0] dest_x_i,
   input  logic signed [COORD_W-1:0] dest_z_i,
   input  logic signed [COORD_W-1:0] start_x_i,
   input  logic signed [COORD_W-1:0] start_z_i,
   output cordic_stage_type          stage_o
);

   localparam int EXT_W = XY_W - (DELTA_W + 1) - PRESCALE_SHIFT;

   cordic_stage_type           stage_in, stage_ff;
   logic signed [DELTA_W-1:0]  dx, dz;
   logic signed [DELTA_W:0]    x0, y0, xf, yf;
   logic signed [ANG_W-1:0]    ang0;

   always_comb begin
      dx = DELTA_W'(dest_x_i) - DELTA_W'(start_x_i);
      dz = DELTA_W'(dest_z_i) - DELTA_W'(start_z_i);
      y0 = -((DELTA_W + 1)'(dx));
      x0 = (DELTA_W + 1)'(dz);
      // fold the left half-plane onto the right one
      if (x0 < 0) begin
         xf   = -x0;
         yf   = -y0;
         ang0 = (y0 >= 0) ? HALF_TURN_Q : -HALF_TURN_Q;
      end else begin
         xf   = x0;
         yf   = y0;
         ang0 = '0;
      end
      stage_in.vld  = vld_i;
      stage_in.zero = (dx == '0) && (dz == '0);
      stage_in.x    = $signed({{EXT_W{xf[DELTA_W]}}, xf, {PRESCALE_SHIFT{1'b0}}});
      stage_in.y    = $signed({{EXT_W{yf[DELTA_W]}}, yf, {PRESCALE_SHIFT{1'b0}}});
      stage_in.ang  = ang0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else if (en_i) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

// ----- design/hyaw_cell.sv -----
// One CORDIC vectoring rotation with its pipeline register.
// Depends on hyaw_pkg for the stage type and the arctangent table.
module hyaw_cell
   import hyaw_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en_i,
   input  cordic_stage_type stage_i,
   output cordic_stage_type stage_o
);

   localparam logic signed [ANG_W-1:0] ATAN_STEP = atan_q(SHIFT);

   cordic_stage_type        stage_in, stage_ff;
   logic signed [XY_W-1:0]  x, y, xs, ys;
   logic signed [ANG_W-1:0] ang;

   always_comb begin
      x  = stage_i.x;
      y  = stage_i.y;
      ang = stage_i.ang;
      xs = x >>> SHIFT;
      ys = y >>> SHIFT;
      stage_in = stage_i;
      // rotate toward y = 0, both updates from the old values
      if (!y[XY_W-1]) begin
         stage_in.x   = x + ys;
         stage_in.y   = y - xs;
         stage_in.ang = ang + ATAN_STEP;
      end else begin
         stage_in.x   = x - ys;
         stage_in.y   = y + xs;
         stage_in.ang = ang - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else if (en_i) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

// ----- design/hyaw_round.sv -----
// Exit stage: round the angle to centidegrees and wrap into (-180, 180].
// Depends on hyaw_pkg.
module hyaw_round
   import hyaw_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en_i,
   input  cordic_stage_type        stage_i,
   output logic                    vld_o,
   output logic signed [YAW_W-1:0] yaw_o
);

   localparam int R_W = ANG_W + 1 - 16;
   localparam logic signed [R_W-1:0] YAW_MAX   = 19'sd18000;
   localparam logic signed [R_W-1:0] YAW_MIN   = -19'sd18000;
   localparam logic signed [R_W-1:0] FULL_TURN = 19'sd36000;

   logic signed [ANG_W:0]    biased;
   logic signed [R_W-1:0]    r0, r1, r2;
   logic                     vld_in, vld_ff;
   logic signed [YAW_W-1:0]  yaw_in, yaw_ff;

   always_comb begin
      biased = (ANG_W + 1)'(stage_i.ang) + (ANG_W + 1)'(32768);
      r0 = R_W'(biased >>> 16);
      r1 = (r0 > YAW_MAX) ? (r0 - FULL_TURN) : r0;
      r2 = (r1 <= YAW_MIN) ? (r1 + FULL_TURN) : r1;
      vld_in = stage_i.vld;
      // equal points have no direction: report zero
      yaw_in = stage_i.zero ? '0 : YAW_W'(r2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en_i) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_i) begin
         yaw_ff <= yaw_in;
      end
   end

   assign vld_o = vld_ff;
   assign yaw_o = yaw_ff;

endmodule
